/* sv/chr_pkg.sv */
// Package for the hash ring lookup core: request and status codes, FSM states,
// and the controller/datapath command and status structs. No dependencies.
package chr_pkg;

    localparam int HOST_ID_BITS = 8;

    localparam logic [1:0] REQ_INSERT   = 2'd0;
    localparam logic [1:0] REQ_DELETE   = 2'd1;
    localparam logic [1:0] REQ_LOOKUP   = 2'd2;
    localparam logic [1:0] REQ_RESERVED = 2'd3;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_DUP   = 3'd1;
    localparam logic [2:0] ST_NOTFD = 3'd2;
    localparam logic [2:0] ST_FULL  = 3'd3;
    localparam logic [2:0] ST_EMPTY = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE,
        S_WAIT,
        S_DECIDE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_FETCH,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;      // capture request, init search bounds
        logic probe;     // issue read at mid
        logic narrow;    // update lo/hi from read data
        logic shift_rd;  // read entry being moved
        logic shift_wr;  // write moved entry, step index
        logic put_new;   // write new entry at insert slot
        logic fetch;     // read entry at search result, load shift index
        logic finish;    // form result
    } t_cmd;

    typedef struct packed {
        logic       search_done;
        logic       hit;
        logic       full;
        logic       empty;
        logic       shift_done;
        logic [1:0] kind;
    } t_sts;

endpackage

/* sv/chr_datapath.sv */
// Datapath of the hash ring core: sorted position/owner memories, binary search
// bounds, shift index and result registers. Uses chr_pkg.
module chr_datapath
    import chr_pkg::*;
#(
    parameter int RING_ENTRIES = 512
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [1:0]              i_req_type,
    input  logic [31:0]             i_position,
    input  logic [7:0]              i_host_id,
    input  t_cmd                    i_cmd,
    output t_sts                    o_sts,
    output logic [7:0]              o_owner_host,
    output logic [2:0]              o_status,
    output logic [9:0]              o_entry_count
);

    localparam int AW = $clog2(RING_ENTRIES);
    localparam int CW = $clog2(RING_ENTRIES + 1);

    logic [31:0]             r_pos_mem [RING_ENTRIES];
    logic [HOST_ID_BITS-1:0] r_own_mem [RING_ENTRIES];

    logic [1:0]              r_kind;
    logic [31:0]             r_key;
    logic [HOST_ID_BITS-1:0] r_host;
    logic [CW-1:0]           r_count, n_count;
    logic [CW-1:0]           r_lo, r_hi, r_idx;
    logic [31:0]             r_rd_pos;
    logic [HOST_ID_BITS-1:0] r_rd_own;
    logic                    r_full;
    logic                    r_fetched;
    logic                    r_hit_q;
    logic [7:0]              r_owner;
    logic [2:0]              r_status;

    logic [CW-1:0] mid;
    logic [AW-1:0] rd_addr, wr_addr;
    logic          wr_en;
    logic [31:0]   wr_pos;
    logic [HOST_ID_BITS-1:0] wr_own;
    logic          go_right;
    logic          is_ins;
    logic          hit_now;

    assign mid    = r_lo + ((r_hi - r_lo) >> 1);
    assign is_ins = (r_kind == REQ_INSERT);
    // lookup: strictly greater; insert/delete: first not below
    assign go_right = (r_kind == REQ_LOOKUP) ? (r_rd_pos <= r_key) : (r_rd_pos < r_key);

    // once the search has ended, keep reading the result slot (wraps to 0)
    always_comb begin
        rd_addr = mid[AW-1:0];
        if (i_cmd.shift_rd) begin
            rd_addr = is_ins ? AW'(r_idx - CW'(1)) : AW'(r_idx + CW'(1));
        end else if (i_cmd.fetch || (r_lo == r_hi)) begin
            rd_addr = (r_lo >= r_count) ? '0 : r_lo[AW-1:0];
        end
    end

    always_comb begin
        wr_en   = i_cmd.shift_wr | i_cmd.put_new;
        wr_addr = r_idx[AW-1:0];
        wr_pos  = i_cmd.put_new ? r_key  : r_rd_pos;
        wr_own  = i_cmd.put_new ? r_host : r_rd_own;
    end

    always_ff @(posedge i_clk) begin
        r_rd_pos <= r_pos_mem[rd_addr];
        r_rd_own <= r_own_mem[rd_addr];
        if (wr_en) begin
            r_pos_mem[wr_addr] <= wr_pos;
            r_own_mem[wr_addr] <= wr_own;
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.put_new) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.finish && r_kind == REQ_DELETE && r_hit_q) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_req_type;
            r_key  <= i_position;
            r_host <= i_host_id[HOST_ID_BITS-1:0];
            r_lo   <= '0;
            r_hi   <= r_count;
            r_full <= (r_count >= CW'(RING_ENTRIES));
        end
        if (i_cmd.narrow) begin
            if (go_right) begin
                r_lo <= mid + CW'(1);
            end else begin
                r_hi <= mid;
            end
        end
        if (i_cmd.fetch) begin
            r_idx <= is_ins ? r_count : r_lo;
        end
        if (i_cmd.shift_wr) begin
            r_idx <= is_ins ? r_idx - CW'(1) : r_idx + CW'(1);
        end
        if (i_cmd.finish) begin
            unique case (r_kind)
                REQ_INSERT: begin
                    r_owner  <= '0;
                    r_status <= r_hit_q ? ST_DUP : (r_full ? ST_FULL : ST_OK);
                end
                REQ_DELETE: begin
                    r_owner  <= '0;
                    r_status <= r_hit_q ? ST_OK : ST_NOTFD;
                end
                REQ_LOOKUP: begin
                    r_owner  <= (r_count == '0) ? 8'd0 : 8'(r_rd_own);
                    r_status <= (r_count == '0) ? ST_EMPTY : ST_OK;
                end
                default: begin
                    r_owner  <= '0;
                    r_status <= ST_NOTFD;
                end
            endcase
        end
    end

    // hit test: fetch cycle reads entry at lo; compared while r_fetched is set
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fetched <= 1'b0;
        end else begin
            r_fetched <= i_cmd.fetch;
        end
    end
    assign hit_now = (r_lo < r_count) && (r_rd_pos == r_key);
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_hit_q <= 1'b0;
        end else if (r_fetched && r_kind != REQ_LOOKUP) begin
            r_hit_q <= hit_now;
        end
    end

    assign o_sts.search_done = (r_lo == r_hi);
    assign o_sts.hit         = r_fetched ? hit_now : r_hit_q;
    assign o_sts.full        = (r_count >= CW'(RING_ENTRIES));
    assign o_sts.empty       = (r_count == '0);
    assign o_sts.shift_done  = is_ins ? (r_idx == r_lo) : (r_idx + CW'(1) >= r_count);
    assign o_sts.kind        = r_kind;

    assign o_owner_host  = r_owner;
    assign o_status      = r_status;
    assign o_entry_count = 10'(r_count);

endmodule

/* sv/chr_ctrl.sv */
// Controller FSM of the hash ring core: sequences search, hit check, shift and
// result. Uses chr_pkg.
module chr_ctrl
    import chr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy,
    output logic o_done
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (i_start) n_state = S_PROBE;
            S_PROBE:    n_state = i_sts.search_done ? S_FETCH : S_WAIT;
            S_WAIT:     n_state = S_DECIDE;
            S_DECIDE:   n_state = S_PROBE;
            S_FETCH:    n_state = S_SHIFT_RD;
            S_SHIFT_RD: begin
                // first visit: fetched data is valid, hit known
                if (i_sts.kind == REQ_INSERT) begin
                    if (i_sts.hit || i_sts.full || i_sts.shift_done) n_state = S_DONE;
                    else n_state = S_SHIFT_WR;
                end else if (i_sts.kind == REQ_DELETE) begin
                    if (!i_sts.hit || i_sts.shift_done) n_state = S_DONE;
                    else n_state = S_SHIFT_WR;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SHIFT_WR: n_state = i_sts.shift_done ? S_DONE : S_SHIFT_WR;
            S_DONE:     n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    logic r_sh;  // shift loop alternates read/write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sh <= 1'b0;
        end else if (r_state == S_SHIFT_WR) begin
            r_sh <= ~r_sh;
        end else begin
            r_sh <= 1'b0;
        end
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = (r_state != S_IDLE);
        o_done = 1'b0;
        unique case (r_state)
            S_IDLE:     o_cmd.load = i_start;
            S_PROBE:    o_cmd.probe = 1'b1;
            S_WAIT:     ;
            S_DECIDE:   o_cmd.narrow = 1'b1;
            S_FETCH:    o_cmd.fetch = 1'b1;
            S_SHIFT_RD: begin
                o_cmd.shift_rd = (n_state == S_SHIFT_WR);
                o_cmd.put_new  = (i_sts.kind == REQ_INSERT) && !i_sts.hit && !i_sts.full
                                 && i_sts.shift_done;
            end
            S_SHIFT_WR: begin
                o_cmd.shift_rd = r_sh;
                o_cmd.shift_wr = !r_sh;
                o_cmd.put_new  = r_sh && i_sts.shift_done && (i_sts.kind == REQ_INSERT);
            end
            S_DONE: begin
                o_cmd.finish = 1'b1;
            end
            default: ;
        endcase
        o_done = (r_state == S_DONE);
    end

endmodule

/* sv/consistent_hash_ring_core.sv */
// Top level of the consistent hash ring lookup core.
// Instantiates chr_ctrl and chr_datapath; uses chr_pkg.
//
// Usage: drive i_req_type, i_position, i_host_id and raise start while
// busy is low; the request is taken at that edge. Exactly one result per
// request appears for one cycle with o_valid high: o_owner_host, o_status,
// o_entry_count. The receiver cannot stall; results are simply presented.
// Each binary search step is a probe, a wait for the synchronous memory read
// and a decide, over up to ceil(log2(entries+1)) steps; then come a final
// probe, fetch, check and result, and the strobe is registered from the
// result state. busy drops in the strobe cycle, so the next request can be
// taken at the edge that ends it; one request is in flight at a time.
// Insert and delete also shift the entries above the slot one at a time,
// each moved by a read and then a write.
// Reset (synchronous, active low) empties the ring; memory contents are not
// cleared, and entries at or above the entry count are never used.
module consistent_hash_ring_core
    import chr_pkg::*;
#(
    parameter int RING_ENTRIES = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_position,
    input  logic [7:0]  i_host_id,
    output logic        o_valid,
    output logic [7:0]  o_owner_host,
    output logic [2:0]  o_status,
    output logic [9:0]  o_entry_count
);

    t_cmd cmd;
    t_sts sts;
    logic done;
    logic r_valid;

    chr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (done)
    );

    chr_datapath #(
        .RING_ENTRIES (RING_ENTRIES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_type    (i_req_type),
        .i_position    (i_position),
        .i_host_id     (i_host_id),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_owner_host  (o_owner_host),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= done;
        end
    end
    assign o_valid = r_valid;

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_busy_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request not taken");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_entry_count <= 10'(RING_ENTRIES))
        else $error("entry count overflow");

    a_empty_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> o_owner_host == 8'd0)
        else $error("owner set on failed request");

endmodule

/* tb/consistent_hash_ring_checker.sv */
// Checker for the hash ring lookup core: watches the request and result ports,
// keeps its own sorted ring and compares every result. Uses chr_pkg.
`timescale 1ns / 1ps
module consistent_hash_ring_checker
    import chr_pkg::*;
#(
    parameter int RING_ENTRIES = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_position,
    input  logic [7:0]  i_host_id,
    input  logic        o_valid,
    input  logic [7:0]  o_owner_host,
    input  logic [2:0]  o_status,
    input  logic [9:0]  o_entry_count,
    output int          fail_count,
    output int          pending_count
);

    typedef struct {
        logic [31:0] pos;
        logic [7:0]  host;
    } t_vnode;

    typedef struct {
        logic [7:0] owner;
        logic [2:0] status;
        logic [9:0] count;
    } t_answer;

    t_vnode  ring_q[$];
    t_answer answer_q[$];

    function automatic int first_at_or_above(logic [31:0] key);
        int i;
        for (i = 0; i < ring_q.size(); i++)
            if (ring_q[i].pos >= key) return i;
        return ring_q.size();
    endfunction

    function automatic t_answer serve(logic [1:0] kind, logic [31:0] pos, logic [7:0] host);
        t_answer a;
        t_vnode  v;
        int      i;
        a.owner  = '0;
        a.status = ST_OK;
        i = first_at_or_above(pos);
        case (kind)
            REQ_INSERT: begin
                if (i < ring_q.size() && ring_q[i].pos == pos) begin
                    a.status = ST_DUP;
                end else if (ring_q.size() >= RING_ENTRIES) begin
                    a.status = ST_FULL;
                end else begin
                    v.pos  = pos;
                    v.host = host;
                    ring_q.insert(i, v);
                end
            end
            REQ_DELETE: begin
                if (i < ring_q.size() && ring_q[i].pos == pos) ring_q.delete(i);
                else a.status = ST_NOTFD;
            end
            REQ_LOOKUP: begin
                if (ring_q.size() == 0) begin
                    a.status = ST_EMPTY;
                end else begin
                    if (i < ring_q.size() && ring_q[i].pos == pos) i++;
                    if (i >= ring_q.size()) i = 0;
                    a.owner = ring_q[i].host;
                end
            end
            default: a.status = ST_NOTFD;
        endcase
        a.count = 10'(ring_q.size());
        return a;
    endfunction

    initial fail_count = 0;
    initial pending_count = 0;

    always @(posedge i_clk) begin
        t_answer exp_a;
        if (!i_rst_n) begin
            ring_q.delete();
            answer_q.delete();
        end else begin
            if (o_valid) begin
                if (answer_q.size() == 0) begin
                    $error("result with no request outstanding");
                    fail_count++;
                end else begin
                    exp_a = answer_q.pop_front();
                    if (o_owner_host !== exp_a.owner) begin
                        $error("owner_host expected %0d actual %0d", exp_a.owner, o_owner_host);
                        fail_count++;
                    end
                    if (o_status !== exp_a.status) begin
                        $error("status expected %0d actual %0d", exp_a.status, o_status);
                        fail_count++;
                    end
                    if (o_entry_count !== exp_a.count) begin
                        $error("entry_count expected %0d actual %0d",
                               exp_a.count, o_entry_count);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                answer_q.push_back(serve(i_req_type, i_position, i_host_id));
        end
        pending_count = answer_q.size();
    end

endmodule

/* tb/consistent_hash_ring_core_tb.sv */
// Testbench top for consistent_hash_ring_core: clock, reset and request
// stimulus; checking is done by consistent_hash_ring_checker. Uses chr_pkg.
`timescale 1ns / 1ps
module consistent_hash_ring_core_tb;
    import chr_pkg::*;

    localparam int  RING_MAX    = 512;
    localparam longint CYCLE_LIMIT = 8000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_req_type = REQ_LOOKUP;
    logic [31:0] i_position = '0;
    logic [7:0]  i_host_id = '0;
    logic        o_valid;
    logic [7:0]  o_owner_host;
    logic [2:0]  o_status;
    logic [9:0]  o_entry_count;
    int          fail_count;
    int          pending_count;
    longint      cycle_count = 0;

    logic [31:0] used_pos[$];

    always #5 i_clk = ~i_clk;

    consistent_hash_ring_core #(.RING_ENTRIES(RING_MAX)) u_top (
        .i_clk, .i_rst_n, .start, .busy, .i_req_type, .i_position, .i_host_id,
        .o_valid, .o_owner_host, .o_status, .o_entry_count
    );

    consistent_hash_ring_checker #(.RING_ENTRIES(RING_MAX)) u_checker (
        .i_clk, .i_rst_n, .start, .busy, .i_req_type, .i_position, .i_host_id,
        .o_valid, .o_owner_host, .o_status, .o_entry_count,
        .fail_count, .pending_count
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL consistent_hash_ring_core");
            $finish;
        end
    end

    int burst_left = 0;

    // Holds start high until the request is taken; afterwards start stays high except during a random idle gap.
    task automatic send_request(logic [1:0] kind, logic [31:0] pos, logic [7:0] host);
        int gap;
        start      <= 1'b1;
        i_req_type <= kind;
        i_position <= pos;
        i_host_id  <= host;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (kind == REQ_INSERT) used_pos.push_back(pos);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(0, 15);
        end
    endtask

    function automatic logic [31:0] pick_position();
        logic [31:0] p;
        int r;
        r = $urandom_range(0, 9);
        if (used_pos.size() > 0 && r < 5) begin
            p = used_pos[$urandom_range(0, used_pos.size() - 1)];
            case ($urandom_range(0, 3))
                0: p = p + 1;
                1: p = p - 1;
                default: ;
            endcase
        end else if (r == 5) begin
            p = 32'h0;
        end else if (r == 6) begin
            p = 32'hFFFF_FFFF;
        end else begin
            p = $urandom;
        end
        return p;
    endfunction

    function automatic logic [1:0] pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 28) return REQ_INSERT;
        if (r < 50) return REQ_DELETE;
        if (r < 95) return REQ_LOOKUP;
        return REQ_RESERVED;
    endfunction

    initial begin
        int n;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(REQ_LOOKUP, 32'h1234_5678, 8'h00);
        send_request(REQ_DELETE, 32'h0000_0000, 8'h00);
        send_request(REQ_RESERVED, 32'hFFFF_FFFF, 8'hFF);
        send_request(REQ_INSERT, 32'h8000_0000, 8'hA5);
        send_request(REQ_LOOKUP, 32'h8000_0000, 8'h00);
        send_request(REQ_LOOKUP, 32'h7FFF_FFFF, 8'h00);
        send_request(REQ_INSERT, 32'h0000_0000, 8'h00);
        send_request(REQ_INSERT, 32'hFFFF_FFFF, 8'hFF);
        send_request(REQ_INSERT, 32'h8000_0000, 8'h5A);
        send_request(REQ_LOOKUP, 32'h0000_0000, 8'h00);
        send_request(REQ_LOOKUP, 32'hFFFF_FFFF, 8'h00);
        send_request(REQ_LOOKUP, 32'hFFFF_FFFE, 8'h00);
        send_request(REQ_DELETE, 32'h1234_5678, 8'h00);
        send_request(REQ_DELETE, 32'hFFFF_FFFF, 8'h00);
        send_request(REQ_LOOKUP, 32'hFFFF_FFFF, 8'h00);
        send_request(REQ_DELETE, 32'h0000_0000, 8'h00);
        send_request(REQ_DELETE, 32'h8000_0000, 8'h00);
        send_request(REQ_LOOKUP, 32'h0000_0001, 8'h00);
        send_request(REQ_RESERVED, 32'h0000_0000, 8'h00);

        for (n = 0; n < 400; n++) begin
            if (u_checker.pending_count >= 0 && used_pos.size() > 60)
                used_pos.delete(0);
            send_request(pick_kind(), pick_position(), 8'($urandom));
        end

        // fill to capacity, then exercise a full ring
        for (n = 0; n < 600; n++)
            send_request(REQ_INSERT, $urandom, 8'($urandom));
        for (n = 0; n < 250; n++) begin
            if ($urandom_range(0, 4) == 0)
                send_request(REQ_INSERT, pick_position(), 8'($urandom));
            else
                send_request(REQ_LOOKUP, pick_position(), 8'($urandom));
        end

        // delete every tracked position, with some lookups between
        while (used_pos.size() > 0) begin
            n = $urandom_range(0, used_pos.size() - 1);
            send_request(REQ_DELETE, used_pos[n], 8'($urandom));
            used_pos.delete(n);
            if ($urandom_range(0, 7) == 0)
                send_request(REQ_LOOKUP, $urandom, 8'($urandom));
        end
        send_request(REQ_LOOKUP, $urandom, 8'($urandom));

        start <= 1'b0;
        while (pending_count > 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASS consistent_hash_ring_core");
        else
            $display("FAIL consistent_hash_ring_core");
        $finish;
    end

endmodule
